// File: rtl/core/ffba_pkg.sv
// ffba_pkg: word types, status and register codes, control bundles
// shared by the allocator controller, datapath and top level
// no dependencies
package ffba_pkg;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd2;

  // register reset values
  localparam logic [31:0] RST_BASE_ADDRESS = 32'd0;
  localparam logic [15:0] RST_BLOCK_SIZE   = 16'd64;
  localparam logic [8:0]  RST_BLOCK_COUNT  = 9'd256;

  // divider geometry
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        operation;
    logic [23:0] size_bytes;
    logic [31:0] free_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] alloc_address;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       div_start;
    logic       div_sel;
    logic       need_ld;
    logic       first_ld;
    logic       last_ld;
    logic       idx_clr;
    logic       idx_run;
    logic       idx_first;
    logic       idx_inc;
    logic       run_upd;
    logic       mem_rd;
    logic       clr_wr;
    logic       mark_wr;
    logic       free_wr;
    logic       mul_sel;
    logic       mul_ld;
    logic       res_ld;
    logic       res_addr;
    logic [2:0] res_code;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic size_zero;
    logic is_free;
    logic div_done;
    logic scan_end;
    logic clear_end;
    logic found;
    logic mark_end;
    logic in_range;
    logic free_end;
    logic past;
    logic not_alloc;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/core/ffba_div.sv
// ffba_div: restoring unsigned divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle
// depends on ffba_pkg
module ffba_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic                      busy_r;
  logic                      done_r;
  logic [ffba_pkg::DIV_CW-1:0] cnt_r;
  logic [16:0]               rem_r;
  logic [31:0]               q_r;
  logic [15:0]               dvs_r;
  logic [16:0]               rem_sh;
  logic                      ge;
  logic [16:0]               rem_nxt;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r[15:0], q_r[31]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ffba_pkg::DIV_CW'(ffba_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: rtl/core/ffba_datapath.sv
// ffba_datapath: request register, bitmap memory, index and run counters,
// shared divider, address multiplier and result register
// depends on ffba_pkg and ffba_div
module ffba_datapath #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ffba_pkg::cmd_t           cmd,
  output ffba_pkg::sts_t           sts,
  input  ffba_pkg::in_word_t       in_word,
  input  logic [31:0]              base,
  input  logic [15:0]              bs_eff,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0] n_eff,
  input  logic                     out_stall,
  output logic                     out_valid,
  output ffba_pkg::out_word_t      out_word
);

  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int PW = NW + 16;

  ffba_pkg::in_word_t  req_r;
  ffba_pkg::out_word_t out_word_r;
  logic                out_valid_r;

  logic [NW-1:0] idx_r, run_r, start_r, end_r, first_r, last_r;
  logic [31:0]   need_r;
  logic          past_r, not_alloc_r;
  logic          rd_data_r;
  logic [PW-1:0] prod_r;
  logic          mem [MAX_BLOCKS];

  logic [31:0] div_dvd, quot;
  logic        div_done;
  logic [32:0] last_sum;
  logic        last_past;
  logic        found;
  logic        mem_we;
  logic [NW-1:0] mul_a;
  logic [32:0] end_addr;

  // request word
  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= in_word;
  end

  // divider operand select: byte length rounded up, or offset into region
  assign div_dvd = cmd.div_sel
                 ? (req_r.free_address - base)
                 : (32'(req_r.size_bytes) + 32'(bs_eff) - 32'd1);

  ffba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (bs_eff),
    .done     (div_done),
    .quotient (quot)
  );

  // run bounds for free
  assign last_sum  = 33'(first_r) + 33'(quot);
  assign last_past = last_sum > 33'(n_eff);

  always_ff @(posedge clk) begin
    if (cmd.need_ld)  need_r  <= quot;
    if (cmd.first_ld) first_r <= quot[NW-1:0];
    if (cmd.last_ld) begin
      past_r <= last_past;
      last_r <= last_past ? n_eff : last_sum[NW-1:0];
    end
    if (cmd.latch)                      not_alloc_r <= 1'b0;
    else if (cmd.free_wr && !rd_data_r) not_alloc_r <= 1'b1;
  end

  // block index
  always_ff @(posedge clk) begin
    if (!rst_n)             idx_r <= '0;
    else if (cmd.idx_clr)   idx_r <= '0;
    else if (cmd.idx_run)   idx_r <= start_r;
    else if (cmd.idx_first) idx_r <= first_r;
    else if (cmd.idx_inc)   idx_r <= idx_r + 1'b1;
  end

  // free run tracking during the first-fit scan
  assign found = !rd_data_r && ((32'(run_r) + 32'd1) >= need_r);

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      run_r <= '0;
    end else if (cmd.run_upd) begin
      if (rd_data_r) begin
        run_r <= '0;
      end else begin
        if (run_r == '0) start_r <= idx_r;
        run_r <= run_r + 1'b1;
        if (found) end_r <= idx_r;
      end
    end
  end

  // used bitmap
  assign mem_we = cmd.clr_wr | cmd.mark_wr | cmd.free_wr;

  always_ff @(posedge clk) begin
    if (mem_we)     mem[idx_r[AW-1:0]] <= cmd.mark_wr;
    if (cmd.mem_rd) rd_data_r <= mem[idx_r[AW-1:0]];
  end

  // block times block size: run start or region length
  assign mul_a = cmd.mul_sel ? n_eff : start_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) prod_r <= PW'(mul_a) * PW'(bs_eff);
  end

  assign end_addr = 33'(base) + 33'(prod_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_word_r.status        <= cmd.res_code;
      out_word_r.alloc_address <= cmd.res_addr ? (base + 32'(prod_r)) : 32'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // status to controller
  always_comb begin
    sts.size_zero = req_r.size_bytes == '0;
    sts.is_free   = req_r.operation == ffba_pkg::OP_FREE;
    sts.div_done  = div_done;
    sts.scan_end  = idx_r >= n_eff;
    sts.clear_end = idx_r == NW'(MAX_BLOCKS - 1);
    sts.found     = found;
    sts.mark_end  = idx_r == end_r;
    sts.in_range  = (req_r.free_address >= base) && (33'(req_r.free_address) < end_addr);
    sts.free_end  = idx_r >= last_r;
    sts.past      = past_r;
    sts.not_alloc = not_alloc_r;
    sts.out_busy  = out_valid_r && out_stall;
  end

endmodule

// File: rtl/core/ffba_ctrl.sv
// ffba_ctrl: sequencer for bitmap clearing, first-fit allocate and free
// depends on ffba_pkg
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_NDIV, S_SCAN_RD, S_SCAN_CHK, S_MARK_SET,
    S_MARK, S_AMUL, S_FRANGE, S_FDIV1, S_FDIV2, S_FREE_RD, S_FREE_WR, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] code_r, code_nxt;
  logic       addr_en_r, addr_en_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    code_nxt    = code_r;
    addr_en_nxt = addr_en_r;
    cmd         = '0;
    cmd.res_code = code_r;
    cmd.res_addr = addr_en_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.clear_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        addr_en_nxt = 1'b0;
        if (sts.is_free) begin
          cmd.mul_sel = 1'b1;
          cmd.mul_ld  = 1'b1;
          state_nxt   = S_FRANGE;
        end else if (sts.size_zero) begin
          code_nxt  = ffba_pkg::ST_BAD_SIZE;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_NDIV;
        end
      end
      S_NDIV: begin
        if (sts.div_done) begin
          cmd.need_ld = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          code_nxt  = ffba_pkg::ST_NO_SPACE;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.run_upd = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.found ? S_MARK_SET : S_SCAN_RD;
      end
      S_MARK_SET: begin
        cmd.idx_run = 1'b1;
        state_nxt   = S_MARK;
      end
      S_MARK: begin
        cmd.mark_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.mark_end) state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul_ld  = 1'b1;
        code_nxt    = ffba_pkg::ST_OK;
        addr_en_nxt = 1'b1;
        state_nxt   = S_DONE;
      end
      S_FRANGE: begin
        if (!sts.in_range) begin
          code_nxt  = ffba_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_FDIV1;
        end
      end
      S_FDIV1: begin
        if (sts.div_done) begin
          cmd.first_ld  = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_FDIV2;
        end
      end
      S_FDIV2: begin
        if (sts.div_done) begin
          cmd.last_ld   = 1'b1;
          cmd.idx_first = 1'b1;
          state_nxt     = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        if (sts.free_end) begin
          if (sts.past)           code_nxt = ffba_pkg::ST_RANGE;
          else if (sts.not_alloc) code_nxt = ffba_pkg::ST_NOT_ALLOC;
          else                    code_nxt = ffba_pkg::ST_OK;
          state_nxt = S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_FREE_RD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      code_r    <= ffba_pkg::ST_OK;
      addr_en_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      code_r    <= code_nxt;
      addr_en_r <= addr_en_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

// File: rtl/core/first_fit_block_allocator_top.sv
// first-fit bitmap block allocator: one request word in, one result word out.
// allocate: size divided into blocks, first-fit scan, run marked;
// free: range check, two divisions for run bounds, blocks read and cleared.
// one request in flight; the result register lets the next word in early.
// after reset the bitmap is swept clear with in_stall high
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int CW = (NW > 9) ? NW : 9;

  logic [31:0]   base_address_r;
  logic [15:0]   block_size_r;
  logic [8:0]    block_count_r;
  logic [15:0]   bs_eff;
  logic [NW-1:0] n_eff;

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= ffba_pkg::RST_BASE_ADDRESS;
      block_size_r   <= ffba_pkg::RST_BLOCK_SIZE;
      block_count_r  <= ffba_pkg::RST_BLOCK_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        ffba_pkg::CFG_BASE_ADDRESS: base_address_r <= cfg_data;
        ffba_pkg::CFG_BLOCK_SIZE:   block_size_r   <= cfg_data[15:0];
        ffba_pkg::CFG_BLOCK_COUNT:  block_count_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // zero block size acts as one, block count clamps to capacity
  assign bs_eff = (block_size_r == '0) ? 16'd1 : block_size_r;
  assign n_eff  = (CW'(block_count_r) > CW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS)
                                                         : NW'(block_count_r);

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .base      (base_address_r),
    .bs_eff    (bs_eff),
    .n_eff     (n_eff),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // an accepted word closes the input until its result is queued
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ffba_pkg::ST_OK) |-> out_word.alloc_address == 32'd0)
    else $error("address on a failed result");

  // status stays within the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status <= ffba_pkg::ST_NOT_ALLOC)
    else $error("undefined status code");

endmodule

// File: tb/ffba_checker.sv
// ffba_checker: watches the request and result channels of the allocator,
// predicts each result from its own bitmap and register copy, compares
// depends on ffba_pkg
module ffba_checker #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ffba_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ffba_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  mismatch_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] base_q;
  logic [15:0] bsize_q;
  logic [8:0]  bcount_q;
  logic        used_map [MAX_BLOCKS];
  ffba_pkg::out_word_t expected_results [$];

  assign pending_count = expected_results.size();

  // compute one result and update the bitmap copy
  function automatic ffba_pkg::out_word_t apply_request(ffba_pkg::in_word_t req);
    ffba_pkg::out_word_t res;
    longint unsigned bs, nblk, need, region_end, first, last;
    int unsigned run, start;
    bit          past, not_alloc;
    res = '0;
    bs = (bsize_q == 0) ? 1 : bsize_q;
    nblk = (bcount_q > MAX_BLOCKS) ? MAX_BLOCKS : bcount_q;
    need = (longint'(req.size_bytes) + bs - 1) / bs;
    if (req.operation == ffba_pkg::OP_ALLOC) begin
      res.status = ffba_pkg::ST_NO_SPACE;
      run = 0;
      start = 0;
      if (req.size_bytes == 0) begin
        res.status = ffba_pkg::ST_BAD_SIZE;
      end else begin
        for (int i = 0; i < nblk; i++) begin
          if (used_map[i]) begin
            run = 0;
          end else begin
            if (run == 0) start = i;
            run++;
            if (run >= need) begin
              for (int k = start; k <= i; k++) used_map[k] = 1'b1;
              res.status = ffba_pkg::ST_OK;
              res.alloc_address = 32'(longint'(base_q) + longint'(start) * bs);
              break;
            end
          end
        end
      end
    end else begin
      region_end = longint'(base_q) + nblk * bs;
      if (req.free_address < base_q || longint'(req.free_address) >= region_end) begin
        res.status = ffba_pkg::ST_RANGE;
      end else begin
        first = (longint'(req.free_address) - base_q) / bs;
        last = first + need;
        past = 0;
        not_alloc = 0;
        if (last > nblk) begin
          last = nblk;
          past = 1;
        end
        for (longint unsigned j = first; j < last; j++) begin
          if (!used_map[j]) not_alloc = 1;
          used_map[j] = 1'b0;
        end
        res.status = past ? ffba_pkg::ST_RANGE
                          : (not_alloc ? ffba_pkg::ST_NOT_ALLOC : ffba_pkg::ST_OK);
      end
    end
    return res;
  endfunction

  // track registers, predict on accepted words, compare results
  always @(posedge clk) begin
    ffba_pkg::out_word_t want;
    if (!rst_n) begin
      base_q <= ffba_pkg::RST_BASE_ADDRESS;
      bsize_q <= ffba_pkg::RST_BLOCK_SIZE;
      bcount_q <= ffba_pkg::RST_BLOCK_COUNT;
      for (int i = 0; i < MAX_BLOCKS; i++) used_map[i] = 1'b0;
      expected_results.delete();
      mismatch_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ffba_pkg::CFG_BASE_ADDRESS: base_q <= cfg_data;
          ffba_pkg::CFG_BLOCK_SIZE:   bsize_q <= cfg_data[15:0];
          ffba_pkg::CFG_BLOCK_COUNT:  bcount_q <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_word));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result word %p", out_word);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_word.status
              || want.alloc_address !== out_word.alloc_address) begin
            if (mismatch_count < 10)
              $display("result mismatch: expected status %0d addr %h, got status %0d addr %h",
                       want.status, want.alloc_address, out_word.status,
                       out_word.alloc_address);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
// tb: stimulus and verdict for first_fit_block_allocator_top
// depends on ffba_pkg, the allocator rtl and ffba_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS = 256;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  ffba_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 0;
  ffba_pkg::out_word_t out_word;
  logic      cfg_we = 0;
  logic [1:0]  cfg_index = ffba_pkg::CFG_BASE_ADDRESS;
  logic [31:0] cfg_data = '0;
  int        mismatch_count;
  int        pending_count;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_cycles = 0;
  logic [31:0] cur_base = ffba_pkg::RST_BASE_ADDRESS;
  logic [15:0] cur_bsize = ffba_pkg::RST_BLOCK_SIZE;
  logic [8:0]  cur_bcount = ffba_pkg::RST_BLOCK_COUNT;
  logic [31:0] live_addrs [$];

  first_fit_block_allocator_top #(.MAX_BLOCKS(MAX_BLOCKS)) DUT (.*);

  ffba_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stall: random percentage, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // follow accepted allocations so frees mostly hit live buffers
  always @(posedge clk) begin
    if (out_valid && !out_stall && out_word.status == ffba_pkg::ST_OK
        && out_word.alloc_address != 0)
      if (live_addrs.size() < 64) live_addrs.push_back(out_word.alloc_address);
  end

  // offer one word; valid stays up after acceptance until the next call
  task automatic send_word(logic op, logic [23:0] size, logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{operation: op, size_bytes: size, free_address: addr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every expected result
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic drain_results();
    wait_results();
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_region(logic [31:0] b, logic [15:0] s, logic [8:0] n);
    drain_results();
    write_reg(ffba_pkg::CFG_BASE_ADDRESS, b);
    write_reg(ffba_pkg::CFG_BLOCK_SIZE, {16'h0, s});
    write_reg(ffba_pkg::CFG_BLOCK_COUNT, {23'h0, n});
    cfg_we <= 1'b0;
    cur_base = b;
    cur_bsize = s;
    cur_bcount = n;
    live_addrs.delete();
  endtask

  // random request: mostly alloc of a few blocks or free of a live buffer
  task automatic random_request();
    int unsigned bs, pick, sel;
    logic [31:0] a;
    bs = (cur_bsize == 0) ? 1 : cur_bsize;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_word(ffba_pkg::OP_ALLOC, 24'($urandom_range(1, bs * 6)), $urandom);
    end else if (pick < 80 && live_addrs.size() > 0) begin
      sel = $urandom_range(live_addrs.size() - 1);
      a = live_addrs[sel];
      live_addrs.delete(sel);
      send_word(ffba_pkg::OP_FREE, 24'($urandom_range(1, bs * 3)),
                a + $urandom_range(bs - 1));
    end else if (pick < 90) begin
      a = cur_base + $urandom_range(cur_bcount * bs);
      send_word(ffba_pkg::OP_FREE, 24'($urandom_range(0, bs * 8)), a);
    end else begin
      send_word(1'($urandom_range(1)), 24'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default region, extremes and every status
    send_word(ffba_pkg::OP_ALLOC, 24'd0, 32'hFFFF_FFFF);
    send_word(ffba_pkg::OP_ALLOC, 24'd1, 32'd0);
    send_word(ffba_pkg::OP_ALLOC, 24'd65, 32'd0);
    send_word(ffba_pkg::OP_ALLOC, 24'hFF_FFFF, 32'd0);
    send_word(ffba_pkg::OP_FREE, 24'd64, 32'd64);
    send_word(ffba_pkg::OP_FREE, 24'd64, 32'd64);
    send_word(ffba_pkg::OP_FREE, 24'd0, 32'd0);
    send_word(ffba_pkg::OP_FREE, 24'd64, 32'd16384);
    send_word(ffba_pkg::OP_FREE, 24'hFF_FFFF, 32'd10);
    send_word(ffba_pkg::OP_ALLOC, 24'd16384, 32'd0);
    send_word(ffba_pkg::OP_ALLOC, 24'd1, 32'd0);
    send_word(ffba_pkg::OP_FREE, 24'd200, 32'd16383);
    send_word(ffba_pkg::OP_FREE, 24'd16384, 32'd0);
    // wrap of the address, zero block size, count above the limit
    set_region(32'hFFFF_FF00, 16'd0, 9'd511);
    send_word(ffba_pkg::OP_ALLOC, 24'd300, 32'd0);
    send_word(ffba_pkg::OP_FREE, 24'd300, 32'hFFFF_FF00);
    send_word(ffba_pkg::OP_FREE, 24'd1, 32'hFFFF_FEFF);
    send_word(ffba_pkg::OP_FREE, 24'd1, 32'hFFFF_FFFF);
    // empty region, widest block
    set_region(32'h1234_5678, 16'hFFFF, 9'd0);
    send_word(ffba_pkg::OP_ALLOC, 24'd1, 32'd0);
    send_word(ffba_pkg::OP_FREE, 24'd1, 32'h1234_5678);
    set_region(32'h8000_0000, 16'hFFFF, 9'd256);
    send_word(ffba_pkg::OP_ALLOC, 24'hFF_FFFF, 32'd0);
    send_word(ffba_pkg::OP_FREE, 24'hFF_FFFF, 32'h8000_0000);

    // random phases across idling patterns and region settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 24; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 24; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: set_region(32'd0, 16'd64, 9'd32);
        1: set_region(32'($urandom), 16'($urandom_range(1, 100)), 9'($urandom_range(8, 40)));
        2: set_region(32'hFFFF_F000, 16'd7, 9'd16);
        3: set_region(32'($urandom), 16'd1, 9'd64);
        4: set_region(32'h0000_1000, 16'($urandom), 9'd24);
        default: set_region(32'd0, 16'd3, 9'd20);
      endcase
      if (phase == 2) hold_cycles = 4000;
      for (int n = 0; n < 72; n++) begin
        random_request();
        if (n == 36) begin
          // pause until every expected result is in
          wait_results();
        end
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // limit on the whole run
  initial begin
    #(12ns * 2000000);
    $display("Mismatches found");
    $finish;
  end
endmodule
